/* rtl/wwkc_pkg.sv */
// Package for the whole-word keyword counter: sizes, the word-close beat
// type and the small helper functions shared by the assembler and the cells.
// No dependencies.
`default_nettype none

package wwkc_pkg;

    localparam int MAX_WORD_BYTES = 8;
    localparam int NUM_KEYWORDS   = 4;
    localparam int COUNT_BITS     = 32;

    localparam int SLOTS          = 4;
    localparam int KEY_BYTES      = 8;
    localparam int KEY_BITS       = 8 * KEY_BYTES;
    localparam int WORD_BITS      = 8 * MAX_WORD_BYTES;
    localparam int OUT_COUNT_BITS = 32;
    localparam int HIT_BITS       = 3;
    localparam int CFG_IDX_BITS   = $clog2(SLOTS);
    // Length also holds the too-long mark MAX_WORD_BYTES + 1
    localparam int LEN_BITS       = $clog2(MAX_WORD_BYTES + 2);
    localparam int KLEN_BITS      = $clog2(KEY_BYTES + 1);
    localparam int LANE_BITS      = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    localparam logic [LEN_BITS-1:0] LEN_MAX  = LEN_BITS'(MAX_WORD_BYTES);
    localparam logic [LEN_BITS-1:0] LEN_LONG = LEN_BITS'(MAX_WORD_BYTES + 1);

    // One closed word, handed to the keyword cells
    typedef struct packed {
        logic                  close;
        logic [KEY_BITS-1:0]   word;
        logic [LEN_BITS-1:0]   len;
    } t_word_close;

    typedef logic [COUNT_BITS-1:0] t_count;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    endfunction

    // Index of the highest nonzero byte plus one
    function automatic logic [KLEN_BITS-1:0] key_length(input logic [KEY_BITS-1:0] k);
        logic [KLEN_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (k[8*i +: 8] != 8'd0) begin
                n = KLEN_BITS'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/wwkc_if.sv */
// Valid/ready channel interfaces for the keyword counter: the byte input
// channel and the count result channel. Uses wwkc_pkg.
`default_nettype none

interface wwkc_in_if
    import wwkc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       final_req;
    logic       restart;

    modport source (output valid, char_byte, final_req, restart, input ready);
    modport sink   (input valid, char_byte, final_req, restart, output ready);
endinterface

interface wwkc_out_if
    import wwkc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OUT_COUNT_BITS-1:0] count_a;
    logic [OUT_COUNT_BITS-1:0] count_b;
    logic [OUT_COUNT_BITS-1:0] count_c;
    logic [OUT_COUNT_BITS-1:0] count_d;
    logic [HIT_BITS-1:0]       hit;

    modport source (output valid, count_a, count_b, count_c, count_d, hit, input ready);
    modport sink   (input valid, count_a, count_b, count_c, count_d, hit, output ready);
endinterface

`default_nettype wire

/* rtl/whole_word_keyword_counter_unit.sv */
// Whole-word keyword counter: one byte beat in, one count beat out.
// The result beat is held in an output register; throughput 1 byte per cycle while the
// output is not stalled, with the close/compare done combinationally in the keyword cells.
// The output register frees as its beat is taken, so input is taken then too.
// Synchronous active-low reset clears keywords, counters and the word.
// Uses wwkc_pkg, wwkc_if, wwkc_word and wwkc_cell.
`default_nettype none

module whole_word_keyword_counter_unit
    import wwkc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    wwkc_in_if.sink                      i_in,
    wwkc_out_if.source                   o_out,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [KEY_BITS-1:0]     i_cfg_data
);

    logic                      accept;
    t_word_close               close;
    logic [LEN_BITS-1:0]       word_len;
    logic [NUM_KEYWORDS:0]     claim;
    logic [NUM_KEYWORDS-1:0]   hits;
    t_count                    cnt_next [SLOTS];
    logic [HIT_BITS-1:0]       hit_code;

    logic                      r_out_valid;
    logic [OUT_COUNT_BITS-1:0] r_count [SLOTS];
    logic [HIT_BITS-1:0]       r_hit;

    // Take a beat whenever the output register is empty or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    wwkc_word u_word (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in.char_byte),
        .i_final  (i_in.final_req),
        .o_close  (close),
        .o_len    (word_len)
    );

    // Row of keyword cells; the claim bit gives the lowest slot priority
    assign claim[0] = 1'b0;
    for (genvar s = 0; s < SLOTS; s++) begin : g_slot
        if (s < NUM_KEYWORDS) begin : g_cell
            wwkc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cfg_we     (i_cfg_we && (i_cfg_idx == CFG_IDX_BITS'(s))),
                .i_cfg_data   (i_cfg_data),
                .i_accept     (accept),
                .i_restart    (i_in.restart),
                .i_close      (close),
                .i_claim      (claim[s]),
                .o_claim      (claim[s+1]),
                .o_hit        (hits[s]),
                .o_count_next (cnt_next[s])
            );
        end else begin : g_empty
            assign cnt_next[s] = '0;
        end
    end

    // Encode the single winning cell as index plus one
    always_comb begin
        hit_code = '0;
        for (int s = 0; s < NUM_KEYWORDS; s++) begin
            if (hits[s]) begin
                hit_code = hit_code | HIT_BITS'(s + 1);
            end
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_count[s] <= OUT_COUNT_BITS'(cnt_next[s]);
            end
            r_hit <= hit_code;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.count_a = r_count[0];
    assign o_out.count_b = r_count[1];
    assign o_out.count_c = r_count[2];
    assign o_out.count_d = r_count[3];
    assign o_out.hit     = r_hit;

    // At most one cell claims a word
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hits))
        else $error("more than one keyword cell hit");

    // The end of the row is claimed exactly when some cell hits
    a_claim_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        claim[NUM_KEYWORDS] == (hits != '0))
        else $error("claim chain disagrees with the cell hits");

    // A hit needs a closed word of legal length
    a_hit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hits != '0) |-> (close.close && (close.len != '0) && (close.len <= LEN_MAX)))
        else $error("hit without a closed word of legal length");

    // The pending length never passes the too-long mark
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        word_len <= LEN_LONG)
        else $error("word length out of range");

    // A result beat that is held back keeps its hit code
    a_hit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_hit))
        else $error("held result changed its hit code");

endmodule

`default_nettype wire

/* rtl/wwkc_word.sv */
// Word assembler: packs text bytes into the pending word and closes it at
// whitespace or at a final byte. Uses wwkc_pkg.
`default_nettype none

module wwkc_word
    import wwkc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_char,
    input  wire logic        i_final,
    output t_word_close      o_close,
    output logic [LEN_BITS-1:0] o_len
);

    logic [WORD_BITS-1:0] r_buf, n_buf, app_buf;
    logic [LEN_BITS-1:0]  r_len, n_len, app_len;
    logic                 space;

    // Append the byte into the lane given by the current length
    always_comb begin
        space   = is_space(i_char);
        app_buf = r_buf;
        app_len = r_len;
        if (r_len < LEN_MAX) begin
            for (int i = 0; i < MAX_WORD_BYTES; i++) begin
                if (r_len[LANE_BITS-1:0] == LANE_BITS'(i)) begin
                    app_buf[8*i +: 8] = i_char;
                end
            end
            app_len = r_len + LEN_BITS'(1);
        end else begin
            app_len = LEN_LONG;
        end
    end

    // Close the old word at whitespace, the new one at a final byte
    always_comb begin
        o_close.close = space || i_final;
        o_close.word  = space ? KEY_BITS'(r_buf) : KEY_BITS'(app_buf);
        o_close.len   = space ? r_len : app_len;
        n_buf = app_buf;
        n_len = app_len;
        if (o_close.close) begin
            n_buf = '0;
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_len <= '0;
        end else if (i_accept) begin
            r_buf <= n_buf;
            r_len <= n_len;
        end
    end

    assign o_len = r_len;

endmodule

`default_nettype wire

/* rtl/wwkc_cell.sv */
// One keyword cell: holds a keyword, its length and a saturating counter,
// and passes the claim bit on to the next cell. Uses wwkc_pkg.
`default_nettype none

module wwkc_cell
    import wwkc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [KEY_BITS-1:0] i_cfg_data,
    input  wire logic                i_accept,
    input  wire logic                i_restart,
    input  wire t_word_close         i_close,
    input  wire logic                i_claim,
    output logic                     o_claim,
    output logic                     o_hit,
    output t_count                   o_count_next
);

    logic [KEY_BITS-1:0]  r_key;
    logic [KLEN_BITS-1:0] r_klen;
    t_count               r_count, base;
    logic                 match;

    // A zero key has length zero and so never matches
    assign match = i_close.close && (r_klen != '0) && (r_key == i_close.word)
                   && (r_klen == KLEN_BITS'(i_close.len));
    assign o_hit   = match && !i_claim;
    assign o_claim = i_claim || match;

    // Clear on restart first, then count the hit, saturating
    always_comb begin
        base         = i_restart ? '0 : r_count;
        o_count_next = base;
        if (o_hit && (base != '1)) begin
            o_count_next = base + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_klen  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key  <= i_cfg_data;
                r_klen <= key_length(i_cfg_data);
            end
            if (i_accept) begin
                r_count <= o_count_next;
            end
        end
    end

endmodule

`default_nettype wire

/* bench/whole_word_keyword_counter_unit_tb.sv */
// Self-checking bench for whole_word_keyword_counter_unit: directed and random byte streams
// against a running keyword tally kept in the bench. Randomly stalls both channels.
// Depends on wwkc_pkg, wwkc_in_if/wwkc_out_if and the unit itself.
`default_nettype none

module whole_word_keyword_counter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wwkc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 110;
    localparam int PHASES      = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        KW_A = 0,
        KW_B = 1,
        KW_C = 2,
        KW_D = 3
    } t_kw_reg;

    typedef struct packed {
        logic [SLOTS-1:0][OUT_COUNT_BITS-1:0] counts;
        logic [HIT_BITS-1:0]                  hit;
    } t_count_beat;

    // Running tally of whole-word keyword hits; holds the counts owed to the output
    class t_keyword_tally;
        logic [KEY_BITS-1:0] keys [SLOTS];
        t_count              tallies [SLOTS];
        logic [KEY_BITS-1:0] word;
        int                  wlen;
        t_count_beat         owed [$];
        int                  fails;

        function new();
            foreach (keys[s]) begin
                keys[s]    = '0;
                tallies[s] = '0;
            end
            word  = '0;
            wlen  = 0;
            fails = 0;
        endfunction

        function void set_keyword(int s, logic [KEY_BITS-1:0] v);
            keys[s] = v;
        endfunction

        static function int key_bytes(logic [KEY_BITS-1:0] k);
            int n;
            n = 0;
            for (int i = 0; i < KEY_BYTES; i++) begin
                if (k[8*i +: 8] != 8'd0) begin
                    n = i + 1;
                end
            end
            return n;
        endfunction

        static function bit blank(logic [7:0] b);
            return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Compare the pending word against the live slots, lowest slot first
        function logic [HIT_BITS-1:0] close_word();
            logic [HIT_BITS-1:0] h;
            int                  live;
            h    = '0;
            live = (NUM_KEYWORDS < SLOTS) ? NUM_KEYWORDS : SLOTS;
            if (wlen >= 1 && wlen <= MAX_WORD_BYTES) begin
                for (int s = 0; s < live; s++) begin
                    if (keys[s] != '0 && keys[s] == word && key_bytes(keys[s]) == wlen) begin
                        if (tallies[s] != '1) begin
                            tallies[s]++;
                        end
                        h = HIT_BITS'(s + 1);
                        break;
                    end
                end
            end
            word = '0;
            wlen = 0;
            return h;
        endfunction

        // Advance the tally by one accepted input beat
        function void tally_byte(logic [7:0] b, logic fin, logic rst);
            t_count_beat beat;
            int          live;
            live = (NUM_KEYWORDS < SLOTS) ? NUM_KEYWORDS : SLOTS;
            if (rst) begin
                foreach (tallies[s]) begin
                    tallies[s] = '0;
                end
            end
            beat.hit = '0;
            if (blank(b)) begin
                beat.hit = close_word();
            end else begin
                if (wlen < MAX_WORD_BYTES) begin
                    word[8*wlen +: 8] = b;
                    wlen++;
                end else begin
                    wlen = MAX_WORD_BYTES + 1;
                end
                if (fin) begin
                    beat.hit = close_word();
                end
            end
            for (int s = 0; s < SLOTS; s++) begin
                beat.counts[s] = (s < live) ? OUT_COUNT_BITS'(tallies[s]) : '0;
            end
            owed = {owed, beat};
        endfunction

        // Check one output beat against the oldest owed counts
        function void check_beat(t_count_beat got);
            t_count_beat want;
            bit          bad;
            if (owed.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("unexpected count beat: a=%0d b=%0d c=%0d d=%0d hit=%0d",
                             got.counts[0], got.counts[1], got.counts[2], got.counts[3],
                             got.hit);
                end
                return;
            end
            want = owed.pop_front();
            bad  = (got.hit !== want.hit);
            for (int s = 0; s < SLOTS; s++) begin
                bad |= (got.counts[s] !== want.counts[s]);
            end
            if (bad) begin
                fails++;
                if (fails <= 10) begin
                    $display("count mismatch: want a=%0d b=%0d c=%0d d=%0d hit=%0d",
                             want.counts[0], want.counts[1], want.counts[2],
                             want.counts[3], want.hit);
                    $display("                 got a=%0d b=%0d c=%0d d=%0d hit=%0d",
                             got.counts[0], got.counts[1], got.counts[2],
                             got.counts[3], got.hit);
                end
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [KEY_BITS-1:0]     i_cfg_data;

    wwkc_in_if  in_ch ();
    wwkc_out_if out_ch ();

    whole_word_keyword_counter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_keyword_tally      tally = new();
    logic [KEY_BITS-1:0] cur_keys [SLOTS];
    t_kw_reg             kw_regs [SLOTS] = '{KW_A, KW_B, KW_C, KW_D};
    int                  sent;
    int                  cycles = 0;
    bit                  tx_calm;
    bit                  rx_calm = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] text_byte(bit nonzero);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (t_keyword_tally::blank(b) || (nonzero && b == 8'd0));
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
    endfunction

    function automatic bit restart_draw();
        return $urandom_range(0, 49) == 0;
    endfunction

    // Keyword of len bytes; inner bytes are sometimes NUL, the top byte never
    function automatic logic [KEY_BITS-1:0] make_key(int len);
        logic [KEY_BITS-1:0] k;
        k = '0;
        for (int i = 0; i < len; i++) begin
            if (i == len - 1) begin
                k[8*i +: 8] = text_byte(1);
            end else begin
                k[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'd0 : text_byte(0);
            end
        end
        return k;
    endfunction

    // Offer one input beat after a random gap and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic fin, input logic rst);
        int gap;
        if ($urandom_range(0, 24) == 0) begin
            tx_calm = !tx_calm;
        end
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_byte <= b;
        in_ch.final_req <= fin;
        in_ch.restart   <= rst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tally.tally_byte(b, fin, rst);
        sent++;
    endtask

    // Hold the input until every owed count beat has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tally.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write all four keyword registers, one per cycle
    task automatic load_keywords();
        for (int s = 0; s < SLOTS; s++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= kw_regs[s];
            i_cfg_data <= cur_keys[s];
            @(posedge i_clk);
            tally.set_keyword(s, cur_keys[s]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // One word (keyword, near miss or random) and its ending, or a noise byte
    task automatic send_token();
        logic [7:0]          w [$];
        int                  k;
        int                  n;
        int                  pick;
        logic [KEY_BITS-1:0] key;
        bit                  fin_end;
        if ($urandom_range(0, 9) == 0) begin
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, restart_draw());
            return;
        end
        k    = $urandom_range(0, SLOTS - 1);
        key  = cur_keys[k];
        n    = t_keyword_tally::key_bytes(key);
        pick = $urandom_range(0, 99);
        if (n == 0 || pick < 20) begin
            repeat ($urandom_range(1, 11)) w = {w, text_byte(0)};
        end else begin
            for (int i = 0; i < n; i++) begin
                w = {w, key[8*i +: 8]};
            end
            if (pick < 32) begin
                w = {w, (($urandom_range(0, 5) == 0) ? 8'd0 : text_byte(0))};
            end else if (pick < 44 && n > 1) begin
                void'(w.pop_back());
            end else if (pick < 55) begin
                w[$urandom_range(0, n - 1)] = text_byte(0);
            end
        end
        fin_end = ($urandom_range(0, 6) == 0);
        foreach (w[i]) begin
            send_beat(w[i], fin_end && (i == w.size() - 1), restart_draw());
        end
        if (!fin_end) begin
            repeat ($urandom_range(1, 3)) begin
                send_beat(blank_byte(), $urandom_range(0, 9) == 0, restart_draw());
            end
        end
    endtask

    // Output side: random stalls, check every beat taken
    initial begin
        t_count_beat got;
        int          gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 24) == 0) begin
                rx_calm = !rx_calm;
            end
            gap = rx_calm ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            got.counts[0] = out_ch.count_a;
            got.counts[1] = out_ch.count_b;
            got.counts[2] = out_ch.count_c;
            got.counts[3] = out_ch.count_d;
            got.hit       = out_ch.hit;
            tally.check_beat(got);
        end
    end

    // Stimulus
    initial begin
        int target;
        bit paused;
        sent              = 0;
        tx_calm           = 1'b0;
        paused            = 1'b0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= KW_A;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.char_byte  <= 8'd0;
        in_ch.final_req  <= 1'b0;
        in_ch.restart    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Duplicate "ab" in A and B, all-ones eight-byte key, "x\0y" with embedded NUL
        cur_keys[0] = 64'h6261;
        cur_keys[1] = 64'h6261;
        cur_keys[2] = '1;
        cur_keys[3] = 64'h790078;
        load_keywords();

        // Lowest slot wins on a duplicate keyword
        send_beat(8'h61, 1'b0, 1'b0);
        send_beat(8'h62, 1'b0, 1'b0);
        send_beat(CHAR_SPACE, 1'b0, 1'b0);
        // Trailing NUL breaks the match
        send_beat(8'h61, 1'b0, 1'b0);
        send_beat(8'h62, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(CHAR_TAB, 1'b0, 1'b0);
        // Empty words, restart clears the counters
        send_beat(CHAR_SPACE, 1'b0, 1'b1);
        send_beat(CHAR_SPACE, 1'b0, 1'b0);
        // Final on a word byte closes the embedded-NUL keyword
        send_beat(8'h78, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h79, 1'b1, 1'b0);
        // Full-length keyword, closed by whitespace that also carries final
        repeat (KEY_BYTES) send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(CHAR_CR, 1'b1, 1'b0);
        drain();

        // Random phases, each under its own keyword set
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    cur_keys[0] = make_key(1);
                    cur_keys[1] = make_key(1);
                    cur_keys[2] = make_key(KEY_BYTES);
                    cur_keys[3] = make_key(KEY_BYTES);
                end
                1: begin
                    foreach (cur_keys[s]) begin
                        cur_keys[s] = make_key($urandom_range(1, KEY_BYTES));
                    end
                    cur_keys[3] = cur_keys[1];
                end
                2: begin
                    cur_keys[0] = '0;
                    cur_keys[1] = make_key(3);
                    cur_keys[2] = '0;
                    cur_keys[3] = make_key(KEY_BYTES);
                end
                3: begin
                    foreach (cur_keys[s]) begin
                        cur_keys[s] = '0;
                    end
                end
                default: begin
                    foreach (cur_keys[s]) begin
                        cur_keys[s] = make_key($urandom_range(1, KEY_BYTES));
                    end
                end
            endcase
            load_keywords();
            target = sent + PHASE_BYTES;
            while (sent < target) begin
                send_token();
                // Let the output run dry once mid-stream
                if (p == 1 && !paused && sent >= target - PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        if (tally.fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
